// ----- rtl/bdtp_pkg.sv -----
// shared types and constants for the branch direction and target predictor
// no dependencies; imported by every module of the block
`default_nettype none

package bdtp_pkg;

  // fixed widths of the stream fields
  localparam int unsigned FIELD_ADDR_BITS  = 48;
  localparam int unsigned FIELD_TOTAL_BITS = 32;
  localparam int unsigned IN_DATA_BITS     = 104;
  localparam int unsigned OUT_DATA_BITS    = 152;

  typedef logic [FIELD_ADDR_BITS-1:0]  addr_t;
  typedef logic [FIELD_TOTAL_BITS-1:0] total_t;

  // two-bit direction counter codes
  typedef enum logic [1:0] {
    PT  = 2'd0,  // strong taken
    PTN = 2'd1,  // weak taken
    PNT = 2'd2,  // weak not-taken
    PN  = 2'd3   // strong not-taken
  } ctr_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // table port strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctrl_t;

  typedef struct packed {
    logic clear_busy;
  } tbl_status_t;

  // outcome of one lookup
  typedef struct packed {
    logic pred_taken;
    logic dir_wrong;
    logic tgt_wrong;
    logic hit;
  } pred_flags_t;

endpackage

`default_nettype wire

// ----- rtl/bdtp_table.sv -----
// entry memory of the predictor: one read and one write port, registered read
// runs a clearing sweep after reset; uses bdtp_pkg
`default_nettype none

module bdtp_table #(
  parameter int unsigned DEPTH_BITS = 10,
  parameter int unsigned WORD_BITS  = 90
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire bdtp_pkg::tbl_ctrl_t    ctrl,
  input  wire logic [DEPTH_BITS-1:0]  rd_addr,
  input  wire logic [DEPTH_BITS-1:0]  wr_addr,
  input  wire logic [WORD_BITS-1:0]   wr_data,
  output logic [WORD_BITS-1:0]        rd_data,
  output bdtp_pkg::tbl_status_t       status
);
  import bdtp_pkg::*;

  localparam int unsigned DEPTH = 1 << DEPTH_BITS;

  logic [WORD_BITS-1:0]  mem [DEPTH];
  logic [DEPTH_BITS:0]   clr_cnt;
  logic                  clr_busy;
  logic                  we;
  logic [DEPTH_BITS-1:0] wa;
  logic [WORD_BITS-1:0]  wd;

  assign clr_busy          = !clr_cnt[DEPTH_BITS];
  assign status.clear_busy = clr_busy;

  // sweep owns the write port until every valid bit is cleared
  always_comb begin
    if (clr_busy) begin
      we = 1'b1;
      wa = clr_cnt[DEPTH_BITS-1:0];
      wd = '0;
    end else begin
      we = ctrl.wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bdtp_update.sv -----
// tag compare, prediction and counter/target training of one table entry
// combinational; uses bdtp_pkg
`default_nettype none

module bdtp_update #(
  parameter int unsigned AW = 48,
  parameter int unsigned TB = 38
) (
  input  wire logic [AW+TB+3:0]     rd_word,
  input  wire logic [TB-1:0]        in_tag,
  input  wire logic [AW-1:0]        in_tgt,
  input  wire logic                 in_taken,
  output logic [AW+TB+3:0]          wr_word,
  output logic [AW-1:0]             pred_tgt,
  output bdtp_pkg::pred_flags_t     flags
);
  import bdtp_pkg::*;

  localparam int unsigned EW = AW + TB + 4;

  logic          e_valid;
  logic [TB-1:0] e_tag;
  ctr_t          e_ctr;
  logic          e_dir;
  logic [AW-1:0] e_tgt;
  logic          hit;
  ctr_t          cur_ctr;
  logic          cur_dir;
  logic [AW-1:0] cur_tgt;
  ctr_t          n_ctr;
  logic          n_dir;
  logic [AW-1:0] n_tgt;
  logic          flip;

  assign e_valid = rd_word[0];
  assign e_tag   = rd_word[TB:1];
  assign e_ctr   = ctr_t'(rd_word[TB+2:TB+1]);
  assign e_dir   = rd_word[TB+3];
  assign e_tgt   = rd_word[EW-1:TB+4];

  assign hit = e_valid && (e_tag == in_tag);

  // a miss starts from a fresh strong-taken entry with no target
  assign cur_ctr = hit ? e_ctr : PT;
  assign cur_dir = hit ? e_dir : 1'b1;
  assign cur_tgt = hit ? e_tgt : '0;

  always_comb begin
    n_ctr = cur_ctr;
    flip  = 1'b0;
    if (in_taken) begin
      case (cur_ctr)
        PTN:     n_ctr = PT;
        PNT: begin
          n_ctr = PTN;
          flip  = 1'b1;
        end
        PN:      n_ctr = PNT;
        default: n_ctr = PT;
      endcase
    end else begin
      case (cur_ctr)
        PT:      n_ctr = PTN;
        PTN: begin
          n_ctr = PNT;
          flip  = 1'b1;
        end
        PNT:     n_ctr = PN;
        default: n_ctr = PN;
      endcase
    end
    n_dir = flip ? in_taken : cur_dir;
    // zero target counts as unset; a direction flip relearns it
    n_tgt = (flip || (cur_tgt == '0)) ? in_tgt : cur_tgt;
  end

  assign wr_word          = {n_tgt, n_dir, n_ctr, in_tag, 1'b1};
  assign pred_tgt         = cur_tgt;
  assign flags.pred_taken = cur_dir;
  assign flags.dir_wrong  = cur_dir != in_taken;
  assign flags.tgt_wrong  = cur_tgt != in_tgt;
  assign flags.hit        = hit;

endmodule

`default_nettype wire

// ----- rtl/branch_direction_target_predictor.sv -----
// branch direction and target predictor: direct-mapped tagged table with totals
// result: the accepted branch and its table read are registered, then the lookup state loads
// the output register; one branch at a time, set by read then write-back of the
// single entry memory; a waiting result holds the write-back, and so the next input
// reset: a clearing sweep of the table; s_tready stays low until the sweep is done
// uses bdtp_pkg, bdtp_table, bdtp_update
`default_nettype none

module branch_direction_target_predictor #(
  parameter int unsigned INDEX_BITS   = 10,
  parameter int unsigned ADDRESS_BITS = 48,
  parameter int unsigned TOTAL_BITS   = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // branch_address[47:0], branch_target[95:48], actual_taken[96], zero fill
  input  wire logic [bdtp_pkg::IN_DATA_BITS-1:0]    s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // predicted_taken[0], predicted_target[48:1], direction_wrong[49],
  // target_wrong[50], entry_hit[51], branch_total[83:52],
  // direction_miss_total[115:84], target_miss_total[147:116], zero fill
  output logic [bdtp_pkg::OUT_DATA_BITS-1:0]        m_tdata
);
  import bdtp_pkg::*;

  localparam int unsigned AW = (ADDRESS_BITS < FIELD_ADDR_BITS) ? ADDRESS_BITS
                                                                : FIELD_ADDR_BITS;
  localparam int unsigned TB = (AW > INDEX_BITS) ? AW - INDEX_BITS : 1;
  localparam int unsigned EW = AW + TB + 4;

  state_t                state, state_next;
  tbl_ctrl_t             ctrl;
  tbl_status_t           status;
  pred_flags_t           flags;
  logic [EW-1:0]         rd_word;
  logic [EW-1:0]         wr_word;
  logic [AW-1:0]         pred_tgt;
  logic [AW-1:0]         s_addr;
  logic [INDEX_BITS-1:0] in_idx;
  logic [TB-1:0]         in_tag;
  logic [AW-1:0]         in_tgt;
  logic                  in_taken;
  logic                  accept;
  logic                  load;
  logic [TOTAL_BITS-1:0] seen_count, seen_next;
  logic [TOTAL_BITS-1:0] dir_miss_count, dir_miss_next;
  logic [TOTAL_BITS-1:0] tgt_miss_count, tgt_miss_next;

  assign s_addr = AW'(s_tdata[FIELD_ADDR_BITS-1:0]);
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (!status.clear_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // write back only once the output register can take the result
        if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign ctrl.rd_en = accept;
  assign ctrl.wr_en = load;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_idx   <= s_addr[INDEX_BITS-1:0];
      in_tag   <= TB'(s_addr >> INDEX_BITS);
      in_tgt   <= AW'(s_tdata[2*FIELD_ADDR_BITS-1:FIELD_ADDR_BITS]);
      in_taken <= s_tdata[2*FIELD_ADDR_BITS];
    end
  end

  bdtp_table #(
    .DEPTH_BITS (INDEX_BITS),
    .WORD_BITS  (EW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_addr (s_addr[INDEX_BITS-1:0]),
    .wr_addr (in_idx),
    .wr_data (wr_word),
    .rd_data (rd_word),
    .status  (status)
  );

  bdtp_update #(
    .AW (AW),
    .TB (TB)
  ) u_update (
    .rd_word  (rd_word),
    .in_tag   (in_tag),
    .in_tgt   (in_tgt),
    .in_taken (in_taken),
    .wr_word  (wr_word),
    .pred_tgt (pred_tgt),
    .flags    (flags)
  );

  // saturating totals
  always_comb begin
    seen_next     = (&seen_count) ? seen_count : seen_count + 1'b1;
    dir_miss_next = dir_miss_count;
    tgt_miss_next = tgt_miss_count;
    if (flags.dir_wrong && !(&dir_miss_count)) begin
      dir_miss_next = dir_miss_count + 1'b1;
    end
    if (flags.tgt_wrong && !(&tgt_miss_count)) begin
      tgt_miss_next = tgt_miss_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count     <= '0;
      dir_miss_count <= '0;
      tgt_miss_count <= '0;
    end else if (load) begin
      seen_count     <= seen_next;
      dir_miss_count <= dir_miss_next;
      tgt_miss_count <= tgt_miss_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'b0, total_t'(tgt_miss_next), total_t'(dir_miss_next),
                  total_t'(seen_next), flags.hit, flags.tgt_wrong, flags.dir_wrong,
                  addr_t'(pred_tgt), flags.pred_taken};
    end
  end

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (rst)
    status.clear_busy |-> !s_tready)
    else $error("input accepted during clearing sweep");

  a_stalled_totals_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP && m_tvalid && !m_tready) |=> $stable(seen_count))
    else $error("totals moved while result was stalled");

  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    load |=> (m_tvalid && seen_count != '0))
    else $error("write-back did not produce a result");

  a_lookup_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOOKUP))
    else $error("accepted branch not looked up");

endmodule

`default_nettype wire

// ----- verif/tb_branch_direction_target_predictor.sv -----
// testbench for branch_direction_target_predictor: directed and random branch streams
// predicts every outcome locally and checks it field by field; needs bdtp_pkg and the rtl
`timescale 1ns / 1ps

module tb_branch_direction_target_predictor;
  import bdtp_pkg::*;

  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned TAG_W       = FIELD_ADDR_BITS - INDEX_W;
  localparam int unsigned TABLE_DEPTH = 1 << INDEX_W;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int          CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic   pred_taken;
    addr_t  pred_target;
    logic   dir_wrong;
    logic   tgt_wrong;
    logic   hit;
    total_t seen;
    total_t dir_miss;
    total_t tgt_miss;
  } outcome_t;

  class branch_outcome_board;
    bit               entry_valid [TABLE_DEPTH];
    logic [TAG_W-1:0] entry_tag   [TABLE_DEPTH];
    ctr_t             entry_ctr   [TABLE_DEPTH];
    logic             entry_dir   [TABLE_DEPTH];
    addr_t            entry_target[TABLE_DEPTH];
    total_t           seen_total     = '0;
    total_t           dir_miss_total = '0;
    total_t           tgt_miss_total = '0;
    outcome_t         expected_outcomes[$];
    int               mismatch_count = 0;

    function total_t bump(total_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // work out the outcome of one accepted branch and train the local table
    function void note_branch(addr_t addr, addr_t tgt, logic taken);
      logic [INDEX_W-1:0] slot;
      logic [TAG_W-1:0]   tag;
      outcome_t           o;
      ctr_t               c;
      slot  = addr[INDEX_W-1:0];
      tag   = addr[FIELD_ADDR_BITS-1:INDEX_W];
      o     = '0;
      o.hit = entry_valid[slot] && (entry_tag[slot] == tag);
      if (!o.hit) begin
        entry_valid[slot]  = 1'b1;
        entry_tag[slot]    = tag;
        entry_ctr[slot]    = PT;
        entry_dir[slot]    = 1'b1;
        entry_target[slot] = '0;
      end
      o.pred_taken  = entry_dir[slot];
      o.pred_target = entry_target[slot];
      o.dir_wrong   = (entry_dir[slot] != taken);
      o.tgt_wrong   = (entry_target[slot] != tgt);
      seen_total = bump(seen_total);
      if (o.dir_wrong) dir_miss_total = bump(dir_miss_total);
      if (o.tgt_wrong) tgt_miss_total = bump(tgt_miss_total);
      // zero target means unset, learn it
      if (entry_target[slot] == '0) entry_target[slot] = tgt;
      c = entry_ctr[slot];
      if (taken) begin
        case (c)
          PTN: c = PT;
          PNT: begin
            c = PTN;
            entry_dir[slot]    = 1'b1;
            entry_target[slot] = tgt;
          end
          PN: c = PNT;
          default: ;
        endcase
      end else begin
        case (c)
          PT: c = PTN;
          PTN: begin
            c = PNT;
            entry_dir[slot]    = 1'b0;
            entry_target[slot] = tgt;
          end
          PNT: c = PN;
          default: ;
        endcase
      end
      entry_ctr[slot] = c;
      o.seen     = seen_total;
      o.dir_miss = dir_miss_total;
      o.tgt_miss = tgt_miss_total;
      expected_outcomes.push_back(o);
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_outcome(logic [OUT_DATA_BITS-1:0] d);
      outcome_t e;
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result transaction with no branch pending");
        return;
      end
      e = expected_outcomes.pop_front();
      compare_field("predicted_taken",      64'(d[0]),       64'(e.pred_taken));
      compare_field("predicted_target",     64'(d[48:1]),    64'(e.pred_target));
      compare_field("direction_wrong",      64'(d[49]),      64'(e.dir_wrong));
      compare_field("target_wrong",         64'(d[50]),      64'(e.tgt_wrong));
      compare_field("entry_hit",            64'(d[51]),      64'(e.hit));
      compare_field("branch_total",         64'(d[83:52]),   64'(e.seen));
      compare_field("direction_miss_total", 64'(d[115:84]),  64'(e.dir_miss));
      compare_field("target_miss_total",    64'(d[147:116]), 64'(e.tgt_miss));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;

  int    send_idle_pct = 25;
  int    recv_idle_pct = 69;
  int    cycle_count   = 0;
  addr_t pool_addr[POOL_SIZE];
  addr_t pool_tgt [POOL_SIZE];
  int    pool_bias[POOL_SIZE];

  branch_outcome_board board;

  branch_direction_target_predictor #(
    .INDEX_BITS  (INDEX_W),
    .ADDRESS_BITS(FIELD_ADDR_BITS),
    .TOTAL_BITS  (FIELD_TOTAL_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL branch_direction_target_predictor");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_outcome(m_tdata);
  end

  function automatic addr_t rand_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  // one branch transaction, with a random hold-off before it
  task automatic send_branch(input addr_t addr, input addr_t tgt, input logic taken);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99, 0) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, taken, tgt, addr};
    do @(posedge clk); while (!s_tready);
    board.note_branch(addr, tgt, taken);
  endtask

  task automatic run_directed();
    addr_t ones;
    ones = '1;
    // fresh entry with a zero target: zero stays unset
    send_branch('0, '0, 1'b1);
    send_branch('0, 48'h1234_5678_9abc, 1'b1);
    // walk the counter through every state both ways
    send_branch('0, 48'h1234_5678_9abc, 1'b0);
    send_branch('0, 48'h0fed_cba9_8765, 1'b0);
    send_branch('0, 48'h0fed_cba9_8765, 1'b0);
    send_branch('0, 48'h0fed_cba9_8765, 1'b0);
    send_branch('0, 48'h0000_0000_0001, 1'b1);
    send_branch('0, 48'h0000_0000_0002, 1'b1);
    send_branch('0, 48'h0000_0000_0002, 1'b1);
    send_branch('0, 48'h0000_0000_0002, 1'b1);
    send_branch(ones, ones, 1'b1);
    send_branch(ones, '0, 1'b0);
    // same slot, other tag: eviction and back
    send_branch(48'h0000_0000_0400, 48'h0000_0000_0040, 1'b0);
    send_branch('0, 48'h0000_0000_0002, 1'b1);
    send_branch(48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 1'b0);
    send_branch(48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 1'b1);
    send_branch(48'haaaa_aaaa_aaaa, '0, 1'b0);
  endtask

  // mostly recurring branches with a per-branch bias, some of them sharing slots
  task automatic run_random(input int count);
    int    pick;
    addr_t addr;
    addr_t tgt;
    logic  taken;
    repeat (count) begin
      if ($urandom_range(99, 0) < 85) begin
        pick  = $urandom_range(POOL_SIZE - 1, 0);
        addr  = pool_addr[pick];
        taken = ($urandom_range(99, 0) < pool_bias[pick]);
        case ($urandom_range(19, 0))
          0, 1:    tgt = rand_addr();
          2:       tgt = '0;
          default: tgt = pool_tgt[pick];
        endcase
      end else begin
        addr  = rand_addr();
        tgt   = rand_addr();
        taken = 1'($urandom_range(1, 0));
      end
      send_branch(addr, tgt, taken);
    end
  endtask

  initial begin
    int biases[5];
    board  = new;
    biases = '{0, 5, 50, 95, 100};
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_addr[i] = rand_addr();
      if (i >= 16) pool_addr[i][INDEX_W-1:0] = pool_addr[i-16][INDEX_W-1:0];
      pool_tgt[i]  = rand_addr();
      pool_bias[i] = biases[$urandom_range(4, 0)];
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(633);
    send_idle_pct = 69;
    recv_idle_pct = 25;
    run_random(633);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(633);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("PASS branch_direction_target_predictor");
    end else begin
      $display("FAIL branch_direction_target_predictor");
    end
    $finish;
  end

endmodule
